### hdl/assert_macros.svh
// Assertion macros used by the session RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Checks that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tfts_pkg.sv
// Types and constants shared by the TFTP transfer session modules.
package tfts_pkg;

    localparam logic [15:0] DEFAULT_BLOCK = 16'd512;
    localparam logic [15:0] HEADER_BYTES  = 16'd4;
    localparam logic [15:0] OP_DATA       = 16'd3;
    localparam logic [15:0] OP_ACK        = 16'd4;
    localparam logic [3:0]  RETRY_CAP     = 4'd15;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_IP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_PORT = 3'd4;

    typedef enum logic [1:0] {
        FN_START   = 2'd0,
        FN_CHUNK   = 2'd1,
        FN_PACKET  = 2'd2,
        FN_TIMEOUT = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ACT_DATA    = 3'd0,
        ACT_ACK     = 3'd1,
        ACT_OACK    = 3'd2,
        ACT_WRITE   = 3'd3,
        ACT_NEED    = 3'd4,
        ACT_DONE    = 3'd5,
        ACT_FAIL    = 3'd6,
        ACT_FOREIGN = 3'd7
    } action_t;

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_OPT_WAIT   = 7'b0000010,
        PH_NEED_CHUNK = 7'b0000100,
        PH_ACK_WAIT   = 7'b0001000,
        PH_RECEIVE    = 7'b0010000,
        PH_DONE       = 7'b0100000,
        PH_FAILED     = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [15:0] block_num;
        logic [15:0] opcode;
        logic [15:0] packet_len;
        logic [15:0] src_port;
        logic [31:0] src_ip;
        logic [15:0] chunk_len;
        func_t       func;
    } event_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] out_block;
        logic [15:0] out_length;
    } result_t;

    // One event's worth of results; count is 1 to 3 for anything queued.
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
    } bundle_t;

endpackage

### hdl/tfts_front.sv
// Front end: configuration registers, session state and event classification.
module tfts_front
    import tfts_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  ev_valid,
    input  logic                  ev_ready,
    input  event_t                ev,
    output logic                  push,
    output bundle_t               push_bundle
);

    logic        direction_reg;
    logic [15:0] block_size_reg;
    logic [3:0]  max_retries_reg;
    logic [31:0] client_ip_reg;
    logic [15:0] client_port_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] cur_block_reg, cur_block_next;
    logic [15:0] held_len_reg, held_len_next;
    logic [3:0]  retry_reg, retry_next;
    logic [15:0] acked_reg, acked_next;
    logic [15:0] peer_port_reg, peer_port_next;

    logic        non_default;
    logic        ip_match;
    logic        peer_learn;
    logic        peer_ok;
    logic        short_pkt;
    logic        held_short;
    logic [15:0] chunk_cut;
    logic [15:0] pay_len;
    logic [15:0] pay_cut;
    logic [3:0]  retry_inc;
    logic [15:0] prev_block;
    logic [15:0] next_block;
    bundle_t     bundle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg   <= 1'b0;
            block_size_reg  <= DEFAULT_BLOCK;
            max_retries_reg <= 4'd5;
            client_ip_reg   <= 32'd0;
            client_port_reg <= 16'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DIRECTION:   direction_reg   <= cfg_data[0];
                CFG_BLOCK_SIZE:  block_size_reg  <= cfg_data[15:0];
                CFG_MAX_RETRIES: max_retries_reg <= cfg_data[3:0];
                CFG_CLIENT_IP:   client_ip_reg   <= cfg_data[31:0];
                CFG_CLIENT_PORT: client_port_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign non_default = block_size_reg != DEFAULT_BLOCK;
    assign ip_match    = ev.src_ip == client_ip_reg;
    assign peer_learn  = ip_match && (acked_reg == 16'd0) && (peer_port_reg == 16'd0);
    assign peer_ok     = peer_learn || (ip_match && ev.src_port == peer_port_reg);
    assign short_pkt   = ev.packet_len < HEADER_BYTES;
    assign held_short  = held_len_reg < block_size_reg;
    assign chunk_cut   = (ev.chunk_len > block_size_reg) ? block_size_reg : ev.chunk_len;
    assign pay_len     = ev.packet_len - HEADER_BYTES;
    assign pay_cut     = (pay_len > block_size_reg) ? block_size_reg : pay_len;
    assign retry_inc   = (retry_reg < RETRY_CAP) ? retry_reg + 4'd1 : retry_reg;
    assign prev_block  = cur_block_reg - 16'd1;
    assign next_block  = cur_block_reg + 16'd1;

    always_comb begin
        phase_next     = phase_reg;
        cur_block_next = cur_block_reg;
        held_len_next  = held_len_reg;
        retry_next     = retry_reg;
        acked_next     = acked_reg;
        peer_port_next = peer_port_reg;
        bundle         = '0;

        if (ev.func == FN_START) begin
            cur_block_next = 16'd1;
            held_len_next  = 16'd0;
            retry_next     = 4'd0;
            acked_next     = 16'd0;
            peer_port_next = client_port_reg;
            bundle.count   = 2'd1;
            if (!direction_reg) begin
                if (non_default) begin
                    phase_next           = PH_OPT_WAIT;
                    bundle.res[0].action = ACT_OACK;
                end else begin
                    phase_next              = PH_NEED_CHUNK;
                    bundle.res[0].action    = ACT_NEED;
                    bundle.res[0].out_block = 16'd1;
                end
            end else begin
                phase_next           = PH_RECEIVE;
                bundle.res[0].action = non_default ? ACT_OACK : ACT_ACK;
            end
        end else begin
            unique case (phase_reg)
                PH_OPT_WAIT: begin
                    if (ev.func == FN_TIMEOUT || (ev.func == FN_PACKET && short_pkt)) begin
                        phase_next           = PH_FAILED;
                        bundle.count         = 2'd1;
                        bundle.res[0].action = ACT_FAIL;
                    end else if (ev.func == FN_PACKET) begin
                        if (peer_learn) peer_port_next = ev.src_port;
                        bundle.count = 2'd1;
                        if (!peer_ok) begin
                            bundle.res[0].action = ACT_FOREIGN;
                        end else if (ev.opcode == OP_ACK && ev.block_num == 16'd0) begin
                            phase_next              = PH_NEED_CHUNK;
                            bundle.res[0].action    = ACT_NEED;
                            bundle.res[0].out_block = cur_block_reg;
                        end else begin
                            phase_next           = PH_FAILED;
                            bundle.res[0].action = ACT_FAIL;
                        end
                    end
                end
                PH_NEED_CHUNK: begin
                    if (ev.func == FN_CHUNK) begin
                        held_len_next            = chunk_cut;
                        retry_next               = 4'd0;
                        phase_next               = PH_ACK_WAIT;
                        bundle.count             = 2'd1;
                        bundle.res[0].action     = ACT_DATA;
                        bundle.res[0].out_block  = cur_block_reg;
                        bundle.res[0].out_length = chunk_cut;
                    end
                end
                PH_ACK_WAIT: begin
                    if (ev.func == FN_TIMEOUT) begin
                        retry_next   = retry_inc;
                        bundle.count = 2'd1;
                        if (retry_inc >= max_retries_reg) begin
                            phase_next           = held_short ? PH_DONE : PH_FAILED;
                            bundle.res[0].action = held_short ? ACT_DONE : ACT_FAIL;
                        end else begin
                            bundle.res[0].action     = ACT_DATA;
                            bundle.res[0].out_block  = cur_block_reg;
                            bundle.res[0].out_length = held_len_reg;
                        end
                    end else if (ev.func == FN_PACKET) begin
                        bundle.count             = 2'd1;
                        bundle.res[0].action     = ACT_DATA;
                        bundle.res[0].out_block  = cur_block_reg;
                        bundle.res[0].out_length = held_len_reg;
                        if (!short_pkt) begin
                            if (peer_learn) peer_port_next = ev.src_port;
                            if (!peer_ok) begin
                                // Flag the stranger, then resend the block anyway.
                                bundle.count             = 2'd2;
                                bundle.res[0]            = '0;
                                bundle.res[0].action     = ACT_FOREIGN;
                                bundle.res[1].action     = ACT_DATA;
                                bundle.res[1].out_block  = cur_block_reg;
                                bundle.res[1].out_length = held_len_reg;
                            end else if (ev.opcode == OP_ACK &&
                                         ev.block_num == cur_block_reg) begin
                                acked_next    = ev.block_num;
                                bundle.res[0] = '0;
                                if (held_short) begin
                                    phase_next           = PH_DONE;
                                    bundle.res[0].action = ACT_DONE;
                                end else begin
                                    cur_block_next          = next_block;
                                    phase_next              = PH_NEED_CHUNK;
                                    bundle.res[0].action    = ACT_NEED;
                                    bundle.res[0].out_block = next_block;
                                end
                            end
                        end
                    end
                end
                PH_RECEIVE: begin
                    if (ev.func == FN_PACKET && !short_pkt) begin
                        if (peer_learn) peer_port_next = ev.src_port;
                        if (!peer_ok) begin
                            bundle.count         = 2'd1;
                            bundle.res[0].action = ACT_FOREIGN;
                        end else if (ev.opcode == OP_DATA) begin
                            if (ev.block_num == cur_block_reg) begin
                                acked_next               = ev.block_num;
                                bundle.count             = 2'd2;
                                bundle.res[0].action     = ACT_WRITE;
                                bundle.res[0].out_block  = ev.block_num;
                                bundle.res[0].out_length = pay_cut;
                                bundle.res[1].action     = ACT_ACK;
                                bundle.res[1].out_block  = ev.block_num;
                                if (pay_cut < block_size_reg) begin
                                    phase_next           = PH_DONE;
                                    bundle.count         = 2'd3;
                                    bundle.res[2].action = ACT_DONE;
                                end else begin
                                    cur_block_next = next_block;
                                end
                            end else if (ev.block_num == prev_block) begin
                                bundle.count            = 2'd1;
                                bundle.res[0].action    = ACT_ACK;
                                bundle.res[0].out_block = ev.block_num;
                            end
                        end
                    end
                end
                PH_IDLE, PH_DONE, PH_FAILED: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            cur_block_reg <= 16'd1;
            held_len_reg  <= 16'd0;
            retry_reg     <= 4'd0;
            acked_reg     <= 16'd0;
            peer_port_reg <= 16'd0;
        end else if (ev_valid && ev_ready) begin
            phase_reg     <= phase_next;
            cur_block_reg <= cur_block_next;
            held_len_reg  <= held_len_next;
            retry_reg     <= retry_next;
            acked_reg     <= acked_next;
            peer_port_reg <= peer_port_next;
        end
    end

    assign push        = ev_valid && ev_ready && (bundle.count != 2'd0);
    assign push_bundle = bundle;

endmodule

### hdl/tfts_queue.sv
// Short queue of result bundles between the front and back ends.
`include "assert_macros.svh"
module tfts_queue
    import tfts_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_bundle,
    input  logic    pop,
    output bundle_t head,
    output logic    not_empty,
    output logic    full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bundle_t          slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + CNT_W'(1);
        else if (pop && !push) count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign full      = count_reg == FULL_CNT;

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= FULL_CNT, "queue count overflow")
    `ASSERT_ALWAYS(a_no_push_full, aclk, aresetn, !(push && full), "push into full queue")
    `ASSERT_ALWAYS(a_no_pop_empty, aclk, aresetn, !(pop && !not_empty), "pop from empty queue")
    `ASSERT_NEXT(a_push_lands, aclk, aresetn, push && !pop, not_empty, "pushed bundle lost")

endmodule

### hdl/tfts_back.sv
// Back end: unpacks queued bundles into result words on the output stream.
module tfts_back
    import tfts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  bundle_t     head,
    input  logic        not_empty,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    output logic [7:0]  m_tuser
);

    bundle_t    cur_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       is_last;
    logic       taken;
    result_t    word;

    assign word    = cur_reg.res[idx_reg];
    assign is_last = idx_reg == (cur_reg.count - 2'd1);
    assign taken   = busy_reg && m_tready;
    // A new bundle loads when nothing is held or the last word of the held one leaves.
    assign pop     = not_empty && (!busy_reg || (taken && is_last));

    always_ff @(posedge aclk) begin
        if (pop) cur_reg <= head;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else if (pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end else if (taken) begin
            if (is_last) begin
                busy_reg <= 1'b0;
                idx_reg  <= 2'd0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = {word.out_length, word.out_block};
    assign m_tlast  = is_last;
    assign m_tuser  = {5'd0, word.action};

endmodule

### hdl/tftp_transfer_session.sv
// Top level of the lock-step TFTP transfer session engine.
// Each event word (start, chunk ready, packet received, timeout) is taken by the
// front end, which updates the session and produces up to three result words;
// these wait in a queue of QUEUE_DEPTH events and leave the back end one word
// per cycle while m_tready is high, so a busy stream sustains one event per
// bundle of result words. s_tready drops only while the queue is full.
// Configuration writes are always taken. Direction and client port
// take effect at the next start, while block size, retry limit and peer address
// apply to the next event at once.
module tftp_transfer_session
    import tfts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // chunk_len[15:0], src_ip[47:16], src_port[63:48], packet_len[79:64],
    // opcode[95:80], block_num[111:96]
    input  logic [111:0]          s_tdata,
    // func[1:0]
    input  logic [7:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_block[15:0], out_length[31:16]
    output logic [31:0]           m_tdata,
    output logic                  m_tlast,
    // action[2:0]
    output logic [7:0]            m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    event_t  ev;
    logic    push;
    bundle_t push_bundle;
    logic    pop;
    bundle_t head;
    logic    not_empty;
    logic    full;

    assign ev.func       = func_t'(s_tuser[1:0]);
    assign ev.chunk_len  = s_tdata[15:0];
    assign ev.src_ip     = s_tdata[47:16];
    assign ev.src_port   = s_tdata[63:48];
    assign ev.packet_len = s_tdata[79:64];
    assign ev.opcode     = s_tdata[95:80];
    assign ev.block_num  = s_tdata[111:96];

    assign s_tready  = !full;
    assign cfg_ready = 1'b1;

    tfts_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ev_valid    (s_tvalid),
        .ev_ready    (s_tready),
        .ev          (ev),
        .push        (push),
        .push_bundle (push_bundle)
    );

    tfts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .head        (head),
        .not_empty   (not_empty),
        .full        (full)
    );

    tfts_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
